/* sv/wsm_pkg.sv */
`default_nettype none

package wsm_pkg;

  localparam int PAT_LEN = 32;
  localparam int ACT_W   = PAT_LEN + 1;
  localparam int POS_W   = 5;
  localparam int LEN_W   = 6;
  localparam int CHAR_W  = 8;
  localparam int OP_W    = 2;
  localparam int IDX_W   = 2;
  localparam int LVL_N   = $clog2(ACT_W);

  localparam logic [OP_W-1:0] OP_PAT    = 2'd0;
  localparam logic [OP_W-1:0] OP_SRC    = 2'd1;
  localparam logic [OP_W-1:0] OP_END    = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [IDX_W-1:0] REG_PATTERN_LENGTH   = 2'd0;
  localparam logic [IDX_W-1:0] REG_CASE_INSENSITIVE = 2'd1;

  localparam logic [CHAR_W-1:0] CH_STAR  = 8'd42;
  localparam logic [CHAR_W-1:0] CH_QUEST = 8'd63;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'd65;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'd90;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'd97;

endpackage

`default_nettype wire

/* sv/wildcard_string_matcher.sv */
// Whole-string wildcard matcher ('*' any run, '?' any one byte).
// Requests arrive on src_valid/src_ready with op, pos, char_code and last.
// A pattern write request (op 0) stores char_code at entry pos. Source byte
// requests (op 1) advance a bit-parallel vector of active pattern positions;
// the byte flagged last, or an end request (op 2), closes the string and
// gives one result on res_valid/res_ready carrying matched.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
// is pattern_length, index 1 case_insensitive. cfg_ready is always high.
// Throughput: one request per clock while the result path is not stalled; the
// active vector update, including a log-depth prefix for star closure, is combinational.
// A request is registered in the input register at acceptance; a result-giving
// request then moves its result into the result register once that is free.
// When the receiver stalls, the result register holds; requests that give
// no result keep flowing, and a result-giving request waits in the input
// register, so src_ready drops only while both registers are full.
// Reset clears both registers' valid flags, the configuration and the open
// string; the pattern store is not cleared and must be written before use.
`default_nettype none

module wildcard_string_matcher (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         src_valid,
  output logic                              src_ready,
  input  wire logic [wsm_pkg::OP_W-1:0]     op,
  input  wire logic [wsm_pkg::POS_W-1:0]    pos,
  input  wire logic [wsm_pkg::CHAR_W-1:0]   char_code,
  input  wire logic                         last,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output logic                              matched,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [wsm_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [wsm_pkg::LEN_W-1:0]    cfg_data
);

  localparam int PAT_LEN = wsm_pkg::PAT_LEN;
  localparam int ACT_W   = wsm_pkg::ACT_W;

  // configuration
  logic [wsm_pkg::LEN_W-1:0] pattern_length;
  logic                      case_insensitive;

  // input register
  logic                        s1_valid;
  logic [wsm_pkg::OP_W-1:0]    s1_op;
  logic [wsm_pkg::POS_W-1:0]   s1_pos;
  logic [wsm_pkg::CHAR_W-1:0]  s1_char;
  logic                        s1_last;

  // match state
  logic [wsm_pkg::CHAR_W-1:0] pat_mem [PAT_LEN];
  logic [ACT_W-1:0]           active;
  logic                       open;

  logic s1_res, res_free, s1_adv, s1_fire;

  logic [wsm_pkg::LEN_W-1:0]  len_use;
  logic [PAT_LEN-1:0]         lt_len, star, hit, prop;
  logic [ACT_W-1:0]           le_len, start_set, base, step, after, final_set;
  logic [wsm_pkg::CHAR_W-1:0] src_fold;

  function automatic logic [wsm_pkg::CHAR_W-1:0] fold(
    input logic [wsm_pkg::CHAR_W-1:0] c,
    input logic                       ci
  );
    logic [wsm_pkg::CHAR_W-1:0] r;
    r = c;
    if (ci && c >= wsm_pkg::CH_UP_A && c <= wsm_pkg::CH_UP_Z) begin
      r = c - wsm_pkg::CH_UP_A + wsm_pkg::CH_LO_A;
    end
    return r;
  endfunction

  // star closure as a parallel prefix: bit j inherits bit j-1 through a star
  function automatic logic [ACT_W-1:0] star_close(
    input logic [ACT_W-1:0]   g_in,
    input logic [PAT_LEN-1:0] pr
  );
    logic [ACT_W-1:0] g, p, g_prev, p_prev;
    int d;
    g = g_in;
    p = {pr, 1'b0};
    for (int lvl = 0; lvl < wsm_pkg::LVL_N; lvl++) begin
      d = 1 << lvl;
      g_prev = g;
      p_prev = p;
      for (int j = 0; j < ACT_W; j++) begin
        if (j >= d) begin
          g[j] = g_prev[j] | (p_prev[j] & g_prev[j-d]);
          p[j] = p_prev[j] & p_prev[j-d];
        end
      end
    end
    return g;
  endfunction

  assign cfg_ready = 1'b1;

  assign s1_res   = (s1_op == wsm_pkg::OP_END) || ((s1_op == wsm_pkg::OP_SRC) && s1_last);
  assign res_free = !res_valid || res_ready;
  assign s1_adv   = !s1_res || res_free;
  assign s1_fire  = s1_valid && s1_adv;
  assign src_ready = !s1_valid || s1_adv;

  always_comb begin
    len_use = (pattern_length > wsm_pkg::LEN_W'(PAT_LEN)) ?
              wsm_pkg::LEN_W'(PAT_LEN) : pattern_length;
    src_fold = fold(s1_char, case_insensitive);
    for (int i = 0; i < PAT_LEN; i++) begin
      lt_len[i] = wsm_pkg::LEN_W'(i) < len_use;
      star[i]   = pat_mem[i] == wsm_pkg::CH_STAR;
      hit[i]    = (pat_mem[i] == wsm_pkg::CH_QUEST) ||
                  (fold(pat_mem[i], case_insensitive) == src_fold);
    end
    for (int i = 0; i < ACT_W; i++) begin
      le_len[i] = wsm_pkg::LEN_W'(i) <= len_use;
    end
    prop = star & lt_len;
    start_set = star_close({{(ACT_W-1){1'b0}}, 1'b1}, prop);
    // positions beyond the length in use are dropped
    base = (open ? active : start_set) & le_len;
    step = '0;
    for (int i = 0; i < PAT_LEN; i++) begin
      if (base[i] && lt_len[i]) begin
        if (star[i]) begin
          step[i]   = 1'b1;
          step[i+1] = 1'b1;
        end else if (hit[i]) begin
          step[i+1] = 1'b1;
        end
      end
    end
    after = star_close(step, prop);
    final_set = (s1_op == wsm_pkg::OP_SRC) ? after : base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length   <= '0;
      case_insensitive <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wsm_pkg::REG_PATTERN_LENGTH:   pattern_length   <= cfg_data;
        wsm_pkg::REG_CASE_INSENSITIVE: case_insensitive <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (src_valid && src_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      s1_op   <= op;
      s1_pos  <= pos;
      s1_char <= char_code;
      s1_last <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_op == wsm_pkg::OP_PAT &&
        {1'b0, s1_pos} < (wsm_pkg::POS_W+1)'(PAT_LEN)) begin
      pat_mem[s1_pos] <= s1_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open   <= 1'b0;
      active <= '0;
    end else if (s1_fire) begin
      unique case (s1_op)
        wsm_pkg::OP_SRC, wsm_pkg::OP_END: begin
          if (s1_res) begin
            open   <= 1'b0;
            active <= '0;
          end else begin
            open   <= 1'b1;
            active <= after;
          end
        end
        wsm_pkg::OP_PAT, wsm_pkg::OP_UNUSED: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && s1_res) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_res) begin
      matched <= final_set[len_use];
    end
  end

`ifndef ASSERT_OFF
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_op == wsm_pkg::OP_END |=> res_valid)
    else $error("end request gave no result");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_op == wsm_pkg::OP_SRC && s1_last |=> res_valid)
    else $error("last source byte gave no result");

  a_result_closes: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_res |=> !open && active == '0)
    else $error("string still open after its result");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !src_ready |-> s1_valid && res_valid && s1_res)
    else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire

/* tb/sv/match_checker.sv */
`default_nettype none

module match_checker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         src_valid,
  input  wire logic                         src_ready,
  input  wire logic [wsm_pkg::OP_W-1:0]     op,
  input  wire logic [wsm_pkg::POS_W-1:0]    pos,
  input  wire logic [wsm_pkg::CHAR_W-1:0]   char_code,
  input  wire logic                         last,
  input  wire logic                         res_valid,
  input  wire logic                         res_ready,
  input  wire logic                         matched,
  input  wire logic                         cfg_valid,
  input  wire logic                         cfg_ready,
  input  wire logic [wsm_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [wsm_pkg::LEN_W-1:0]    cfg_data,
  output int                                fail_count,
  output int                                outstanding
);

  import wsm_pkg::*;

  logic [CHAR_W-1:0] pat_mem [PAT_LEN];
  logic [ACT_W-1:0]  live_pos;
  logic              str_open;
  logic [LEN_W-1:0]  len_reg;
  logic              ci_reg;
  bit                match_due [$];

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    if (ci_reg && c >= CH_UP_A && c <= CH_UP_Z) return c - CH_UP_A + CH_LO_A;
    return c;
  endfunction

  function automatic int live_len();
    return (len_reg > PAT_LEN) ? PAT_LEN : int'(len_reg);
  endfunction

  // follow stars that can be skipped without consuming a byte
  function automatic logic [ACT_W-1:0] close_stars(input logic [ACT_W-1:0] v, input int n);
    int i;
    for (i = 0; i < n; i++)
      if (v[i] && pat_mem[i] == CH_STAR) v[i+1] = 1'b1;
    return v;
  endfunction

  task automatic advance_matcher(input logic [OP_W-1:0] r_op, input logic [POS_W-1:0] r_pos,
                                 input logic [CHAR_W-1:0] r_ch, input logic r_last);
    int n;
    int i;
    logic [ACT_W-1:0] nxt;
    logic [CHAR_W-1:0] pc;
    n = live_len();
    case (r_op)
      OP_PAT: begin
        pat_mem[r_pos] = r_ch;
      end
      OP_SRC, OP_END: begin
        if (!str_open) begin
          live_pos = close_stars({{(ACT_W-1){1'b0}}, 1'b1}, n);
          str_open = 1'b1;
        end
        // positions past a shortened pattern are dropped
        for (i = n + 1; i <= PAT_LEN; i++) live_pos[i] = 1'b0;
        if (r_op == OP_SRC) begin
          nxt = '0;
          for (i = 0; i < n; i++) begin
            if (live_pos[i]) begin
              pc = pat_mem[i];
              if (pc == CH_STAR) begin
                nxt[i]   = 1'b1;
                nxt[i+1] = 1'b1;
              end else if (pc == CH_QUEST || fold_case(pc) == fold_case(r_ch)) begin
                nxt[i+1] = 1'b1;
              end
            end
          end
          live_pos = close_stars(nxt, n);
        end
        if (r_op == OP_END || r_last) begin
          match_due.push_back(live_pos[n]);
          str_open = 1'b0;
          live_pos = '0;
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      live_pos = '0;
      str_open = 1'b0;
      len_reg  = '0;
      ci_reg   = 1'b0;
      match_due.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (match_due.size() == 0)
          report_mismatch($sformatf("result matched=%0b with no request outstanding", matched));
        else if (matched !== match_due[0])
          report_mismatch($sformatf("matched %0b, predicted %0b", matched, match_due.pop_front()));
        else
          void'(match_due.pop_front());
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PATTERN_LENGTH:   len_reg = cfg_data;
          REG_CASE_INSENSITIVE: ci_reg  = cfg_data[0];
          default: begin
          end
        endcase
      end
      if (src_valid && src_ready) advance_matcher(op, pos, char_code, last);
    end
    outstanding = match_due.size();
  end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`default_nettype none

module testbench;

  import wsm_pkg::*;

  localparam int TARGET_REQS = 1950;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              src_valid = 1'b0;
  logic              src_ready;
  logic [OP_W-1:0]   op        = OP_UNUSED;
  logic [POS_W-1:0]  pos       = '0;
  logic [CHAR_W-1:0] char_code = '0;
  logic              last      = 1'b0;
  logic              res_valid;
  logic              res_ready = 1'b0;
  logic              matched;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [LEN_W-1:0]  cfg_data  = '0;

  int fail_count;
  int outstanding;

  // stimulus-side copy of the pattern, used to build strings that match
  logic [CHAR_W-1:0] pat_copy [PAT_LEN];
  int                pat_used;
  int                sent_reqs;
  int                phase_no;
  bit                calm;

  always #5 clk = ~clk;

  wildcard_string_matcher u_dut (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_ready(src_ready),
    .op(op), .pos(pos), .char_code(char_code), .last(last),
    .res_valid(res_valid), .res_ready(res_ready), .matched(matched),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  match_checker u_checker (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_ready(src_ready),
    .op(op), .pos(pos), .char_code(char_code), .last(last),
    .res_valid(res_valid), .res_ready(res_ready), .matched(matched),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always @(negedge clk) res_ready <= calm || ($urandom_range(0, 99) >= 27);

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // entered and left at a falling edge; valid is left high for the next request
  task automatic send_req(input logic [OP_W-1:0] r_op, input logic [POS_W-1:0] r_pos,
                          input logic [CHAR_W-1:0] r_ch, input logic r_last);
    while (!calm && $urandom_range(0, 99) < 27) begin
      src_valid <= 1'b0;
      @(negedge clk);
    end
    src_valid <= 1'b1;
    op        <= r_op;
    pos       <= r_pos;
    char_code <= r_ch;
    last      <= r_last;
    @(posedge clk);
    while (!src_ready) @(posedge clk);
    @(negedge clk);
    if (r_op != OP_UNUSED) sent_reqs++;
  endtask

  task automatic write_cfg(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // hold off until every result is back and the pipeline has emptied
  task automatic wait_drained();
    src_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] pick_pattern_char();
    case ($urandom_range(0, 11))
      0, 1:    return CH_STAR;
      2, 3:    return CH_QUEST;
      4, 5, 6: return "a";
      7, 8:    return "b";
      9:       return "A";
      10:      return "B";
      default: return CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pick_text_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return "a";
      4, 5:       return "b";
      6:          return "A";
      7:          return "B";
      default:    return CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] swap_case(input logic [CHAR_W-1:0] c);
    if (c >= CH_UP_A && c <= CH_UP_Z) return c + 8'd32;
    if (c >= CH_LO_A && c <= CH_LO_A + 8'd25) return c - 8'd32;
    return c;
  endfunction

  task automatic load_pattern(input int n);
    int k;
    pat_used = n;
    for (k = 0; k < n; k++) begin
      pat_copy[k] = pick_pattern_char();
      send_req(OP_PAT, POS_W'(k), pat_copy[k], 1'($urandom_range(0, 1)));
    end
  endtask

  // mostly strings built from the pattern, some mutated, some pure noise
  task automatic send_source();
    logic [CHAR_W-1:0] txt [$];
    int k;
    int j;
    int reps;
    bit close_by_end;
    logic [CHAR_W-1:0] v;
    txt = {};
    if ($urandom_range(0, 9) < 8) begin
      for (k = 0; k < pat_used; k++) begin
        if (pat_copy[k] == CH_STAR) begin
          reps = $urandom_range(0, 3);
          for (j = 0; j < reps; j++) txt.push_back(pick_text_char());
        end else if (pat_copy[k] == CH_QUEST) begin
          txt.push_back(pick_text_char());
        end else begin
          v = pat_copy[k];
          if ($urandom_range(0, 3) == 0) v = swap_case(v);
          txt.push_back(v);
        end
      end
      if ($urandom_range(0, 3) == 0 && txt.size() > 0) begin
        k = $urandom_range(0, txt.size() - 1);
        case ($urandom_range(0, 2))
          0:       txt.delete(k);
          1:       txt.insert(k, pick_text_char());
          default: txt[k] = pick_text_char();
        endcase
      end
    end else begin
      reps = $urandom_range(0, 6);
      for (j = 0; j < reps; j++) txt.push_back(pick_text_char());
    end
    close_by_end = (txt.size() == 0) || ($urandom_range(0, 9) == 0);
    for (j = 0; j < txt.size(); j++) begin
      if ($urandom_range(0, 39) == 0)
        send_req(OP_UNUSED, POS_W'($urandom_range(0, 31)), CHAR_W'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 59) == 0) begin
        // pattern rewrite while a string is open
        k = $urandom_range(0, PAT_LEN - 1);
        pat_copy[k] = pick_pattern_char();
        send_req(OP_PAT, POS_W'(k), pat_copy[k], 1'($urandom_range(0, 1)));
      end
      send_req(OP_SRC, POS_W'($urandom_range(0, 31)), txt[j],
               !close_by_end && (j == txt.size() - 1));
    end
    if (close_by_end)
      send_req(OP_END, POS_W'($urandom_range(0, 31)), CHAR_W'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)));
  endtask

  initial begin
    int len_cfg;
    int n_str;
    int s;
    sent_reqs = 0;
    calm      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty pattern: only an empty source matches; unused op does nothing
    send_req(OP_END, 5'd0, 8'd1, 1'b0);
    send_req(OP_SRC, 5'd31, "a", 1'b1);
    send_req(OP_UNUSED, 5'd0, 8'hff, 1'b1);
    // pattern A ? * <zero byte> <ff>
    send_req(OP_PAT, 5'd0, "A", 1'b0);
    send_req(OP_PAT, 5'd1, CH_QUEST, 1'b0);
    send_req(OP_PAT, 5'd2, CH_STAR, 1'b0);
    send_req(OP_PAT, 5'd3, 8'h00, 1'b0);
    send_req(OP_PAT, 5'd4, 8'hff, 1'b0);
    wait_drained();
    write_cfg(REG_PATTERN_LENGTH, 6'd5);
    write_cfg(REG_CASE_INSENSITIVE, 6'd0);
    send_req(OP_SRC, 5'd0, "A", 1'b0);
    send_req(OP_SRC, 5'd0, "x", 1'b0);
    send_req(OP_SRC, 5'd0, 8'h00, 1'b0);
    send_req(OP_SRC, 5'd0, 8'hff, 1'b1);
    send_req(OP_SRC, 5'd0, "a", 1'b0);
    send_req(OP_SRC, 5'd0, "x", 1'b0);
    send_req(OP_SRC, 5'd0, 8'h00, 1'b0);
    send_req(OP_SRC, 5'd0, 8'hff, 1'b1);
    wait_drained();
    write_cfg(REG_CASE_INSENSITIVE, 6'd1);
    send_req(OP_SRC, 5'd0, "a", 1'b0);
    send_req(OP_SRC, 5'd0, "Z", 1'b0);
    send_req(OP_SRC, 5'd0, "q", 1'b0);
    send_req(OP_SRC, 5'd0, "q", 1'b0);
    send_req(OP_SRC, 5'd0, 8'h00, 1'b0);
    send_req(OP_SRC, 5'd0, 8'hff, 1'b1);
    // end request while a string is open
    send_req(OP_SRC, 5'd0, "A", 1'b0);
    send_req(OP_END, 5'd0, 8'h80, 1'b0);

    phase_no = 0;
    sent_reqs = 0;
    while (sent_reqs < TARGET_REQS) begin
      calm = (phase_no >= 6 && phase_no < 14);
      case (phase_no)
        0: len_cfg = PAT_LEN;
        1: len_cfg = 63;
        2: len_cfg = 0;
        default: begin
          case ($urandom_range(0, 15))
            0, 1:    len_cfg = $urandom_range(9, PAT_LEN);
            2:       len_cfg = $urandom_range(PAT_LEN + 1, 63);
            default: len_cfg = $urandom_range(0, 8);
          endcase
        end
      endcase
      load_pattern((len_cfg > PAT_LEN) ? PAT_LEN : len_cfg);
      wait_drained();
      write_cfg(REG_PATTERN_LENGTH, LEN_W'(len_cfg));
      write_cfg(REG_CASE_INSENSITIVE, {5'($urandom_range(0, 31)), 1'($urandom_range(0, 1))});
      if (phase_no % 10 == 5)
        write_cfg(IDX_W'($urandom_range(2, 3)), LEN_W'($urandom_range(0, 63)));
      n_str = $urandom_range(3, 12);
      for (s = 0; s < n_str; s++) send_source();
      // sometimes leave a string open across the next reconfiguration
      if ($urandom_range(0, 7) == 0) begin
        send_req(OP_SRC, POS_W'($urandom_range(0, 31)), pick_text_char(), 1'b0);
        if ($urandom_range(0, 1) == 1)
          send_req(OP_SRC, POS_W'($urandom_range(0, 31)), pick_text_char(), 1'b0);
      end
      phase_no++;
    end
    calm = 1'b0;
    wait_drained();
    send_req(OP_END, 5'd0, 8'd1, 1'b0);
    wait_drained();

    if (fail_count == 0 && outstanding == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
sv/wsm_pkg.sv
sv/wildcard_string_matcher.sv
tb/sv/match_checker.sv
tb/sv/testbench.sv
